/* rtl/core/mrdp_pkg.sv */
package mrdp_pkg;

  // matrix shape
  localparam int P_ROWS    = 16;
  localparam int R_ROWS    = 16;
  localparam int INNER_LEN = 16;

  // field widths
  localparam int CMD_W = 2;
  localparam int ROW_W = 4;
  localparam int COL_W = 4;
  localparam int VAL_W = 8;
  localparam int DOT_W = 20;

  // derived storage and datapath widths
  localparam int PA_W  = (P_ROWS * INNER_LEN > 1) ? $clog2(P_ROWS * INNER_LEN) : 1;
  localparam int RA_W  = (R_ROWS * INNER_LEN > 1) ? $clog2(R_ROWS * INNER_LEN) : 1;
  localparam int K_W   = $clog2(INNER_LEN);
  localparam int ACC_W = $clog2(((2 ** VAL_W) - 1) * ((2 ** VAL_W) - 1) * INNER_LEN + 1);

  localparam logic [DOT_W-1:0] DOT_MAX = {DOT_W{1'b1}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_P = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_R = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic [VAL_W-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic [DOT_W-1:0] dot_value;
    logic [ROW_W-1:0] p_row;
    logic [COL_W-1:0] r_row;
  } result_t;

  // sequencer to multiply-accumulate
  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

endpackage

/* rtl/core/mrdp_ram.sv */
module mrdp_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/mrdp_mac.sv */
module mrdp_mac (
  input  logic                         clk,
  input  mrdp_pkg::mac_ctrl_t          ctrl,
  input  logic [mrdp_pkg::VAL_W-1:0]   a,
  input  logic [mrdp_pkg::VAL_W-1:0]   b,
  output logic [mrdp_pkg::DOT_W-1:0]   dot_value
);
  import mrdp_pkg::*;

  logic [ACC_W-1:0]       acc;
  logic [2*VAL_W-1:0]     prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // clamp to the result width
  assign dot_value = (32'(acc) > 32'(DOT_MAX)) ? DOT_MAX : DOT_W'(acc);

endmodule

/* rtl/core/matrix_row_dot_product.sv */
// Loads (command 0/1): no result; next beat may follow at once.
// Query (command 2): walks the RUN, DRAIN and DONE states from acceptance to the result
//   register, one multiply-accumulate per inner position read from the two element memories.
// Queries: no new item is taken until a query has left the done state, as the single shared
//   multiply-accumulate serves one query at a time; an out-of-range query skips the walk.
// Reset (rst, synchronous, active high) clears sequencer and result valid; memory contents
//   are not cleared and must be written before being queried.
module matrix_row_dot_product (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  mrdp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output mrdp_pkg::result_t result
);
  import mrdp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [K_W-1:0]   k;            // inner position being read
  logic             rd_v;         // memory data valid this cycle
  logic             zero_q;       // query row out of range
  logic [ROW_W-1:0] p_row_q;
  logic [COL_W-1:0] r_row_q;

  logic             item_take;
  logic             is_query;
  logic             q_in_range;
  logic             p_wr_en, r_wr_en;
  logic [PA_W-1:0]  p_wr_addr, p_rd_addr;
  logic [RA_W-1:0]  r_wr_addr, r_rd_addr;
  logic [VAL_W-1:0] p_rd_data, r_rd_data;
  logic             issue;
  logic             last_k;
  logic             out_free;
  logic [DOT_W-1:0] mac_dot;
  mac_ctrl_t        mac_ctrl;

  // one item in flight; results wait in the output register
  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign is_query   = (item.command == CMD_QUERY);
  assign q_in_range = (32'(item.row_index) < P_ROWS) && (32'(item.col_index) < R_ROWS);

  // load path: out-of-range writes dropped
  assign p_wr_en   = item_take && (item.command == CMD_LOAD_P) &&
                     (32'(item.row_index) < P_ROWS) && (32'(item.col_index) < INNER_LEN);
  assign r_wr_en   = item_take && (item.command == CMD_LOAD_R) &&
                     (32'(item.row_index) < R_ROWS) && (32'(item.col_index) < INNER_LEN);
  assign p_wr_addr = PA_W'(32'(item.row_index) * INNER_LEN + 32'(item.col_index));
  assign r_wr_addr = RA_W'(32'(item.row_index) * INNER_LEN + 32'(item.col_index));

  // query path: walk inner positions of the two rows
  assign issue     = (state == ST_RUN);
  assign last_k    = (k == K_W'(INNER_LEN - 1));
  assign p_rd_addr = PA_W'(32'(p_row_q) * INNER_LEN + 32'(k));
  assign r_rd_addr = RA_W'(32'(r_row_q) * INNER_LEN + 32'(k));

  mrdp_ram #(
    .DEPTH (P_ROWS * INNER_LEN),
    .AW    (PA_W),
    .DW    (VAL_W)
  ) u_p_mem (
    .clk     (clk),
    .wr_en   (p_wr_en),
    .wr_addr (p_wr_addr),
    .wr_data (item.element_value),
    .rd_en   (issue),
    .rd_addr (p_rd_addr),
    .rd_data (p_rd_data)
  );

  mrdp_ram #(
    .DEPTH (R_ROWS * INNER_LEN),
    .AW    (RA_W),
    .DW    (VAL_W)
  ) u_r_mem (
    .clk     (clk),
    .wr_en   (r_wr_en),
    .wr_addr (r_wr_addr),
    .wr_data (item.element_value),
    .rd_en   (issue),
    .rd_addr (r_rd_addr),
    .rd_data (r_rd_data)
  );

  // accumulator cleared as a query is taken, adds each returned pair
  assign mac_ctrl.clear = item_take && is_query;
  assign mac_ctrl.en    = rd_v;

  mrdp_mac u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .a         (p_rd_data),
    .b         (r_rd_data),
    .dot_value (mac_dot)
  );

  // result register can take a new beat
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_take && is_query) begin
          state_next = q_in_range ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rd_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload and walk registers, no reset
  always_ff @(posedge clk) begin
    if (item_take && is_query) begin
      p_row_q <= item.row_index;
      r_row_q <= item.col_index;
      zero_q  <= !q_in_range;
      k       <= '0;
    end else if (issue) begin
      k <= k + K_W'(1);
    end
    if (state == ST_DONE && out_free) begin
      result.dot_value <= zero_q ? '0 : mac_dot;
      result.p_row     <= p_row_q;
      result.r_row     <= r_row_q;
    end
  end

  // walk ends after the last inner position
  a_run_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && last_k) |=> (state == ST_DRAIN))
    else $error("walk did not end at last inner position");

  // final pair must be in flight when draining
  a_drain_data: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> rd_v)
    else $error("drain without pending memory data");

  // a new result only ever comes from the done state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside done state");

  // done hands off as soon as the result register frees
  a_done_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (result_valid && state == ST_IDLE))
    else $error("done state failed to hand off result");

endmodule
